[rtl/core/wsfh_pkg.sv]
// Package with the types and constants of the WebSocket frame header parser.
package wsfh_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned STATUS_W   = 3;
    localparam int unsigned OPCODE_W   = 4;
    localparam int unsigned POS_W      = 4;
    localparam int unsigned FORM_W     = 7;
    localparam int unsigned ACC_W      = 64;
    localparam int unsigned LEN_W      = 63;
    localparam int unsigned MASK_W     = 32;

    localparam logic [BYTE_W-1:0] RSV_BITS_MASK = 8'h70;
    localparam logic [BYTE_W-1:0] CTRL_BIT_MASK = 8'h08;
    localparam logic [FORM_W-1:0] FORM_MAX_DIRECT = 7'd125;
    localparam logic [FORM_W-1:0] FORM_LEN16 = 7'd126;
    localparam logic [FORM_W-1:0] FORM_LEN64 = 7'd127;
    localparam logic [ACC_W-1:0] CTRL_MAX_LEN = 64'd125;
    localparam logic [ACC_W-1:0] LEN16_MIN = 64'd126;
    localparam logic [ACC_W-1:0] LEN16_MAX = 64'h0000_0000_0000_FFFF;

    localparam logic [POS_W-1:0] HDR_MIN_SIZE = 4'd2;
    localparam logic [POS_W-1:0] HDR_MAX_SIZE = 4'd14;
    localparam logic [POS_W-1:0] LEN16_BYTES = 4'd2;
    localparam logic [POS_W-1:0] LEN64_BYTES = 4'd8;
    localparam logic [POS_W-1:0] MASK_BYTES = 4'd4;

    localparam logic [OPCODE_W-1:0] OP_CONT   = 4'h0;
    localparam logic [OPCODE_W-1:0] OP_TEXT   = 4'h1;
    localparam logic [OPCODE_W-1:0] OP_BINARY = 4'h2;
    localparam logic [OPCODE_W-1:0] OP_CLOSE  = 4'h8;
    localparam logic [OPCODE_W-1:0] OP_PING   = 4'h9;
    localparam logic [OPCODE_W-1:0] OP_PONG   = 4'hA;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK                 = 3'd0,
        ST_RESERVED           = 3'd1,
        ST_OPCODE             = 3'd2,
        ST_OVERLONG           = 3'd3,
        ST_NEGATIVE           = 3'd4,
        ST_FRAGMENTED_CONTROL = 3'd5,
        ST_CONTROL_TOO_BIG    = 3'd6
    } t_status;

    typedef struct packed {
        logic [POS_W-1:0]  byte_position;
        logic [BYTE_W-1:0] first_byte;
        logic [FORM_W-1:0] length_form;
        logic              masked_seen;
        logic [ACC_W-1:0]  length_accumulator;
        logic [MASK_W-1:0] mask_accumulator;
    } t_parse_state;

    typedef struct packed {
        t_status              status;
        logic                 fin_flag;
        logic [OPCODE_W-1:0]  frame_opcode;
        logic                 masked_flag;
        logic [LEN_W-1:0]     payload_len;
        logic [MASK_W-1:0]    mask_word;
        logic [POS_W-1:0]     hdr_len;
    } t_result;

endpackage

[rtl/core/wsfh_byte_if.sv]
// Channel interface that carries header bytes.
interface wsfh_byte_if
    import wsfh_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] header_byte;

    modport source (output valid, output header_byte, input ready);
    modport sink (input valid, input header_byte, output ready);
endinterface

[rtl/core/wsfh_result_if.sv]
// Channel interface that carries parsed header results.
interface wsfh_result_if
    import wsfh_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                fin_flag;
    logic [OPCODE_W-1:0] frame_opcode;
    logic                masked_flag;
    logic [LEN_W-1:0]    payload_len;
    logic [MASK_W-1:0]   mask_word;
    logic [POS_W-1:0]    hdr_len;

    modport source (
        output valid, output status, output fin_flag, output frame_opcode,
        output masked_flag, output payload_len, output mask_word, output hdr_len,
        input ready
    );
    modport sink (
        input valid, input status, input fin_flag, input frame_opcode,
        input masked_flag, input payload_len, input mask_word, input hdr_len,
        output ready
    );
endinterface

[rtl/core/wsfh_step_logic.sv]
// Next-state and result logic for one header byte.
module wsfh_step_logic
    import wsfh_pkg::*;
(
    input  t_parse_state      i_state,
    input  logic [BYTE_W-1:0] i_byte,
    output t_parse_state      o_state,
    output logic              o_emit,
    output t_result           o_result
);

    always_comb begin
        t_parse_state     s;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] len_bytes;
        logic [POS_W-1:0] len_end;
        logic [POS_W-1:0] total;
        logic             emit;
        t_status          status;

        s         = i_state;
        pos       = i_state.byte_position + 4'd1;
        emit      = 1'b0;
        status    = ST_OK;
        len_bytes = '0;
        len_end   = '0;
        total     = '0;

        if (pos <= 4'd1) begin
            s.byte_position = 4'd1;
            s.first_byte    = i_byte;
        end else begin
            s.byte_position = pos;
            if (pos == HDR_MIN_SIZE) begin
                if ((i_state.first_byte & RSV_BITS_MASK) != '0) begin
                    emit   = 1'b1;
                    status = ST_RESERVED;
                end else if (!(i_state.first_byte[OPCODE_W-1:0] inside
                        {OP_CONT, OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG})) begin
                    emit   = 1'b1;
                    status = ST_OPCODE;
                end else begin
                    s.masked_seen        = i_byte[BYTE_W-1];
                    s.length_form        = i_byte[FORM_W-1:0];
                    s.length_accumulator = (i_byte[FORM_W-1:0] <= FORM_MAX_DIRECT)
                        ? {{(ACC_W-FORM_W){1'b0}}, i_byte[FORM_W-1:0]} : '0;
                    s.mask_accumulator   = '0;
                end
            end else begin
                if (i_state.length_form == FORM_LEN16) begin
                    len_bytes = LEN16_BYTES;
                end else if (i_state.length_form == FORM_LEN64) begin
                    len_bytes = LEN64_BYTES;
                end
                len_end = HDR_MIN_SIZE + len_bytes;
                if (pos <= len_end) begin
                    s.length_accumulator = {i_state.length_accumulator[ACC_W-BYTE_W-1:0], i_byte};
                    if (pos == len_end) begin
                        if (i_state.length_form == FORM_LEN16) begin
                            if (s.length_accumulator < LEN16_MIN) begin
                                emit   = 1'b1;
                                status = ST_OVERLONG;
                            end
                        end else if (s.length_accumulator[ACC_W-1]) begin
                            emit   = 1'b1;
                            status = ST_NEGATIVE;
                        end else if (s.length_accumulator <= LEN16_MAX) begin
                            emit   = 1'b1;
                            status = ST_OVERLONG;
                        end
                    end
                end else begin
                    s.mask_accumulator = {i_state.mask_accumulator[MASK_W-BYTE_W-1:0], i_byte};
                end
            end

            if (!emit) begin
                len_bytes = '0;
                if (s.length_form == FORM_LEN16) begin
                    len_bytes = LEN16_BYTES;
                end else if (s.length_form == FORM_LEN64) begin
                    len_bytes = LEN64_BYTES;
                end
                total = HDR_MIN_SIZE + len_bytes + (s.masked_seen ? MASK_BYTES : 4'd0);
                if (pos >= total) begin
                    emit = 1'b1;
                    if ((s.first_byte & CTRL_BIT_MASK) != '0) begin
                        if (!s.first_byte[BYTE_W-1]) begin
                            status = ST_FRAGMENTED_CONTROL;
                        end else if (s.length_accumulator > CTRL_MAX_LEN) begin
                            status = ST_CONTROL_TOO_BIG;
                        end
                    end
                end
            end
        end

        o_emit                = emit;
        o_result.status       = status;
        o_result.fin_flag     = s.first_byte[BYTE_W-1];
        o_result.frame_opcode = s.first_byte[OPCODE_W-1:0];
        o_result.hdr_len      = pos;
        if (status == ST_OK) begin
            o_result.masked_flag = s.masked_seen;
            o_result.payload_len = s.length_accumulator[LEN_W-1:0];
            o_result.mask_word   = s.mask_accumulator;
        end else begin
            o_result.masked_flag = 1'b0;
            o_result.payload_len = '0;
            o_result.mask_word   = '0;
        end
        o_state = emit ? '0 : s;
    end

endmodule

[rtl/core/websocket_frame_header_parser_unit.sv]
// Top level of the WebSocket frame header parser: input register, parse state and result register.
// The last byte of a header is held in the input register; its result is then registered in the result register.
// Throughput: one header byte per cycle; a waiting result stalls the input only when the next
// byte also ends a header. The input register and one parse step over the stored state set this.
// Reset: synchronous, active low; clears both valid flags and all parse state to zero.
module websocket_frame_header_parser_unit
    import wsfh_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    wsfh_byte_if.sink     i_byte,
    wsfh_result_if.source o_result
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    t_parse_state      r_state;
    t_parse_state      n_state;
    logic              r_out_valid;
    t_result           r_out;
    t_result           n_out;
    logic              step_emit;
    logic              out_free;
    logic              proceed;

    wsfh_step_logic u_step (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .o_state  (n_state),
        .o_emit   (step_emit),
        .o_result (n_out)
    );

    assign out_free     = !r_out_valid || o_result.ready;
    assign proceed      = r_in_valid && (!step_emit || out_free);
    assign i_byte.ready = !r_in_valid || proceed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (i_byte.ready) begin
                r_in_valid <= i_byte.valid;
            end
            if (proceed) begin
                r_state <= n_state;
            end
            if (proceed && step_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.ready && i_byte.valid) begin
            r_in_byte <= i_byte.header_byte;
        end
        if (proceed && step_emit) begin
            r_out <= n_out;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.status       = r_out.status;
    assign o_result.fin_flag     = r_out.fin_flag;
    assign o_result.frame_opcode = r_out.frame_opcode;
    assign o_result.masked_flag  = r_out.masked_flag;
    assign o_result.payload_len  = r_out.payload_len;
    assign o_result.mask_word    = r_out.mask_word;
    assign o_result.hdr_len      = r_out.hdr_len;

endmodule

[rtl/core/wsfh_checker.sv]
// Port-level checks of the WebSocket frame header parser, bound to its top level.
module wsfh_checker
    import wsfh_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [STATUS_W-1:0] i_status,
    input logic                i_fin_flag,
    input logic [OPCODE_W-1:0] i_frame_opcode,
    input logic                i_masked_flag,
    input logic [LEN_W-1:0]    i_payload_len,
    input logic [MASK_W-1:0]   i_mask_word,
    input logic [POS_W-1:0]    i_hdr_len
);

    a_idle_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !i_out_valid)
        else $error("Result valid right after reset.");

    a_hold_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_hdr_len) && $stable(i_payload_len))
        else $error("Stalled result changed.");

    a_size_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_hdr_len >= HDR_MIN_SIZE && i_hdr_len <= HDR_MAX_SIZE)
        else $error("Header size out of range.");

    a_error_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != ST_OK |->
            !i_masked_flag && i_payload_len == '0 && i_mask_word == '0)
        else $error("Error result carries length or mask data.");

    a_control_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_OK && i_frame_opcode[OPCODE_W-1] |->
            i_fin_flag && {1'b0, i_payload_len} <= CTRL_MAX_LEN)
        else $error("Accepted control frame is fragmented or too long.");

endmodule

bind websocket_frame_header_parser_unit wsfh_checker u_wsfh_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_result.valid),
    .i_out_ready    (o_result.ready),
    .i_status       (o_result.status),
    .i_fin_flag     (o_result.fin_flag),
    .i_frame_opcode (o_result.frame_opcode),
    .i_masked_flag  (o_result.masked_flag),
    .i_payload_len  (o_result.payload_len),
    .i_mask_word    (o_result.mask_word),
    .i_hdr_len      (o_result.hdr_len)
);

[bench/testbench.sv]
// Self-checking testbench for the WebSocket frame header parser unit.
`timescale 1ns / 1ps

module testbench
    import wsfh_pkg::*;
();

    localparam logic [OPCODE_W-1:0] OP_UNDEF_DATA = 4'h3;
    localparam logic [OPCODE_W-1:0] OP_UNDEF_CTRL = 4'hB;
    localparam int unsigned WHOLE_HEADER = 15;
    localparam int unsigned BYTE_TARGET = 1150;

    logic i_clk;
    logic i_rst_n;

    wsfh_byte_if   byte_ch ();
    wsfh_result_if result_ch ();

    websocket_frame_header_parser_unit i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (byte_ch),
        .o_result (result_ch)
    );

    logic [POS_W-1:0]  pos_q;
    logic [BYTE_W-1:0] first_q;
    logic [FORM_W-1:0] form_q;
    logic              masked_q;
    logic [ACC_W-1:0]  len_q;
    logic [MASK_W-1:0] mask_q;

    t_result expected_results[$];
    int      mismatch_count = 0;
    int      result_count = 0;
    int      byte_count = 0;
    bit      idle_on = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic logic [POS_W-1:0] extra_len_bytes();
        if (form_q == FORM_LEN16) begin
            return LEN16_BYTES;
        end
        if (form_q == FORM_LEN64) begin
            return LEN64_BYTES;
        end
        return '0;
    endfunction

    function automatic bit opcode_known(input logic [OPCODE_W-1:0] op);
        return op == OP_CONT || op == OP_TEXT || op == OP_BINARY ||
               op == OP_CLOSE || op == OP_PING || op == OP_PONG;
    endfunction

    task automatic finish_header(input t_status st);
        t_result r;
        r = '0;
        r.status = st;
        r.fin_flag = first_q[7];
        r.frame_opcode = first_q[OPCODE_W-1:0];
        if (st == ST_OK) begin
            r.masked_flag = masked_q;
            r.payload_len = len_q[LEN_W-1:0];
            r.mask_word = mask_q;
        end
        r.hdr_len = pos_q;
        expected_results.insert(expected_results.size(), r);
        pos_q = '0;
        first_q = '0;
        form_q = '0;
        masked_q = 1'b0;
        len_q = '0;
        mask_q = '0;
    endtask

    task automatic track_header_byte(input logic [BYTE_W-1:0] b);
        logic [POS_W-1:0] len_end;
        logic [POS_W-1:0] total;
        pos_q = pos_q + 1'b1;
        if (pos_q <= 4'd1) begin
            pos_q = 4'd1;
            first_q = b;
            return;
        end
        if (pos_q == HDR_MIN_SIZE) begin
            if ((first_q & RSV_BITS_MASK) != 0) begin
                finish_header(ST_RESERVED);
                return;
            end
            if (!opcode_known(first_q[OPCODE_W-1:0])) begin
                finish_header(ST_OPCODE);
                return;
            end
            masked_q = b[7];
            form_q = b[FORM_W-1:0];
            len_q = (form_q <= FORM_MAX_DIRECT) ? ACC_W'(form_q) : '0;
            mask_q = '0;
        end else begin
            len_end = HDR_MIN_SIZE + extra_len_bytes();
            if (pos_q <= len_end) begin
                len_q = {len_q[ACC_W-BYTE_W-1:0], b};
                if (pos_q == len_end) begin
                    if (form_q == FORM_LEN16) begin
                        if (len_q < LEN16_MIN) begin
                            finish_header(ST_OVERLONG);
                            return;
                        end
                    end else begin
                        if (len_q[ACC_W-1]) begin
                            finish_header(ST_NEGATIVE);
                            return;
                        end
                        if (len_q <= LEN16_MAX) begin
                            finish_header(ST_OVERLONG);
                            return;
                        end
                    end
                end
            end else begin
                mask_q = {mask_q[MASK_W-BYTE_W-1:0], b};
            end
        end
        total = HDR_MIN_SIZE + extra_len_bytes() + (masked_q ? MASK_BYTES : 4'd0);
        if (pos_q >= total) begin
            if ((first_q & CTRL_BIT_MASK) != 0) begin
                if (!first_q[7]) begin
                    finish_header(ST_FRAGMENTED_CONTROL);
                    return;
                end
                if (len_q > CTRL_MAX_LEN) begin
                    finish_header(ST_CONTROL_TOO_BIG);
                    return;
                end
            end
            finish_header(ST_OK);
        end
    endtask

    task automatic send_header_byte(input logic [BYTE_W-1:0] b);
        while (idle_on && $urandom_range(99) < 28) begin
            byte_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_ch.valid <= 1'b1;
        byte_ch.header_byte <= b;
        do @(posedge i_clk); while (!byte_ch.ready);
        track_header_byte(b);
        byte_count++;
    endtask

    task automatic send_frame_header(input logic fin, input logic [2:0] rsv,
                                     input logic [OPCODE_W-1:0] op, input logic masked,
                                     input logic [FORM_W-1:0] form, input logic [ACC_W-1:0] length,
                                     input logic [MASK_W-1:0] key, input int unsigned keep);
        logic [BYTE_W-1:0] hdr[$];
        int i;
        hdr.insert(hdr.size(), {fin, rsv, op});
        hdr.insert(hdr.size(), {masked, form});
        if (form == FORM_LEN16) begin
            hdr.insert(hdr.size(), length[15:8]);
            hdr.insert(hdr.size(), length[7:0]);
        end else if (form == FORM_LEN64) begin
            for (i = 7; i >= 0; i--) hdr.insert(hdr.size(), length[i*8 +: 8]);
        end
        if (masked) begin
            for (i = 3; i >= 0; i--) hdr.insert(hdr.size(), key[i*8 +: 8]);
        end
        for (i = 0; i < hdr.size() && i < keep; i++) begin
            send_header_byte(hdr[i]);
            if (pos_q == 0) break;
        end
    endtask

    function automatic logic [OPCODE_W-1:0] pick_opcode();
        case ($urandom_range(5))
            0: return OP_CONT;
            1: return OP_TEXT;
            2: return OP_BINARY;
            3: return OP_CLOSE;
            4: return OP_PING;
            default: return OP_PONG;
        endcase
    endfunction

    task automatic send_random_header();
        logic                fin;
        logic [2:0]          rsv;
        logic [OPCODE_W-1:0] op;
        logic                masked;
        logic [FORM_W-1:0]   form;
        logic [ACC_W-1:0]    length;
        int unsigned         keep;
        fin = 1'($urandom_range(1));
        rsv = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 1)) : 3'd0;
        op = ($urandom_range(9) == 0) ? OPCODE_W'($urandom) : pick_opcode();
        masked = 1'($urandom_range(1));
        length = '0;
        case ($urandom_range(3))
            0, 1: begin
                form = FORM_W'($urandom_range(125));
            end
            2: begin
                form = FORM_LEN16;
                length = ($urandom_range(7) == 0) ? ACC_W'($urandom_range(125))
                                                  : ACC_W'($urandom_range(16'hFFFF, 126));
            end
            default: begin
                form = FORM_LEN64;
                case ($urandom_range(7))
                    0: length = {1'b1, 31'($urandom), $urandom};
                    1: length = ACC_W'($urandom_range(16'hFFFF));
                    default: length = {1'b0, 31'($urandom), $urandom} >> $urandom_range(46);
                endcase
            end
        endcase
        if (op[3] && $urandom_range(1)) begin
            fin = 1'b1;
            form = FORM_W'($urandom_range(125));
        end
        keep = ($urandom_range(19) == 0) ? $urandom_range(13, 1) : WHOLE_HEADER;
        send_frame_header(fin, rsv, op, masked, form, length, $urandom, keep);
    endtask

    task automatic send_random_traffic(input int unsigned until_count);
        while (byte_count < until_count) begin
            if ($urandom_range(99) < 8) begin
                repeat ($urandom_range(12, 1)) send_header_byte(BYTE_W'($urandom));
            end else begin
                send_random_header();
            end
        end
    endtask

    task automatic report_mismatch(input string field, input logic [ACC_W-1:0] got,
                                   input logic [ACC_W-1:0] want);
        mismatch_count++;
        $display("%0t: result %0d %s is %0h, expected %0h", $time, result_count, field, got, want);
    endtask

    task automatic test_first_byte_errors();
        send_frame_header(1'b1, 3'b111, OP_UNDEF_CTRL, 1'b1, 7'd5, '0, '0, WHOLE_HEADER);
        send_frame_header(1'b0, 3'b000, OP_UNDEF_DATA, 1'b0, 7'd1, '0, '0, WHOLE_HEADER);
        send_frame_header(1'b1, 3'b010, OP_TEXT, 1'b0, 7'd1, '0, '0, WHOLE_HEADER);
    endtask

    task automatic test_length_forms();
        send_frame_header(1'b0, 3'b000, OP_CONT, 1'b0, 7'd0, '0, '0, WHOLE_HEADER);
        send_frame_header(1'b1, 3'b000, OP_BINARY, 1'b1, FORM_MAX_DIRECT, '0, 32'hFFFF_FFFF,
                          WHOLE_HEADER);
        send_frame_header(1'b1, 3'b000, OP_TEXT, 1'b1, FORM_LEN16, 64'd125, 32'hA5A5_5A5A,
                          WHOLE_HEADER);
        send_frame_header(1'b1, 3'b000, OP_TEXT, 1'b0, FORM_LEN16, LEN16_MIN, '0, WHOLE_HEADER);
        send_frame_header(1'b1, 3'b000, OP_BINARY, 1'b1, FORM_LEN16, LEN16_MAX, '0, WHOLE_HEADER);
        send_frame_header(1'b1, 3'b000, OP_BINARY, 1'b0, FORM_LEN64, LEN16_MAX, '0, WHOLE_HEADER);
        send_frame_header(1'b1, 3'b000, OP_BINARY, 1'b1, FORM_LEN64, 64'hFFFF_FFFF_FFFF_FFFF,
                          32'h1234_5678, WHOLE_HEADER);
        send_frame_header(1'b0, 3'b000, OP_CONT, 1'b1, FORM_LEN64, 64'h7FFF_FFFF_FFFF_FFFF,
                          32'h8001_7FFE, WHOLE_HEADER);
        send_frame_header(1'b1, 3'b000, OP_TEXT, 1'b0, FORM_LEN64, 64'h1_0000, '0, WHOLE_HEADER);
    endtask

    task automatic test_control_frames();
        send_frame_header(1'b0, 3'b000, OP_CLOSE, 1'b0, 7'd0, '0, '0, WHOLE_HEADER);
        send_frame_header(1'b0, 3'b000, OP_PING, 1'b1, FORM_LEN16, 64'd300, 32'hDEAD_BEEF,
                          WHOLE_HEADER);
        send_frame_header(1'b1, 3'b000, OP_PONG, 1'b0, FORM_LEN16, LEN16_MIN, '0, WHOLE_HEADER);
        send_frame_header(1'b1, 3'b000, OP_PING, 1'b1, FORM_MAX_DIRECT, '0, 32'h0102_0304,
                          WHOLE_HEADER);
    endtask

    task automatic test_steady_stream();
        idle_on = 1'b0;
        send_random_traffic(byte_count + 200);
        idle_on = 1'b1;
    endtask

    task automatic test_random_headers();
        send_random_traffic(BYTE_TARGET);
    endtask

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                result_count++;
                if (expected_results.size() == 0) begin
                    report_mismatch("arrived with nothing expected, status",
                                    ACC_W'(result_ch.status), '0);
                end else begin
                    want = expected_results.pop_front();
                    if (result_ch.status !== want.status)
                        report_mismatch("status", ACC_W'(result_ch.status), ACC_W'(want.status));
                    if (result_ch.fin_flag !== want.fin_flag)
                        report_mismatch("fin_flag", ACC_W'(result_ch.fin_flag),
                                        ACC_W'(want.fin_flag));
                    if (result_ch.frame_opcode !== want.frame_opcode)
                        report_mismatch("frame_opcode", ACC_W'(result_ch.frame_opcode),
                                        ACC_W'(want.frame_opcode));
                    if (result_ch.masked_flag !== want.masked_flag)
                        report_mismatch("masked_flag", ACC_W'(result_ch.masked_flag),
                                        ACC_W'(want.masked_flag));
                    if (result_ch.payload_len !== want.payload_len)
                        report_mismatch("payload_len", ACC_W'(result_ch.payload_len),
                                        ACC_W'(want.payload_len));
                    if (result_ch.mask_word !== want.mask_word)
                        report_mismatch("mask_word", ACC_W'(result_ch.mask_word),
                                        ACC_W'(want.mask_word));
                    if (result_ch.hdr_len !== want.hdr_len)
                        report_mismatch("hdr_len", ACC_W'(result_ch.hdr_len),
                                        ACC_W'(want.hdr_len));
                end
            end
            result_ch.ready <= !(idle_on && $urandom_range(99) < 28);
        end
    end

    initial begin
        pos_q = '0;
        first_q = '0;
        form_q = '0;
        masked_q = 1'b0;
        len_q = '0;
        mask_q = '0;
        i_rst_n <= 1'b0;
        byte_ch.valid <= 1'b0;
        byte_ch.header_byte <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_first_byte_errors();
        test_length_forms();
        test_control_frames();
        test_steady_stream();
        test_random_headers();
        byte_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
